// ----- rtl/dqtf_pkg.sv -----
// Shared types, constants and the sigmoid cell generator for the quantile threshold filter.
package dqtf_pkg;

    // Probabilities are Q1.16 where PROB_ONE means 1.0.
    localparam int PROB_W = 17;
    localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

    // Fixed formats of the ports.
    localparam int VAL_W  = 32;
    localparam int LOSS_W = 48;
    localparam int CNT_W  = 32;
    localparam int PRB_W  = 16;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Constants of the sigmoid cell generator (Q30 arithmetic).
    localparam longint Q30_ONE = 64'sd1 <<< 30;
    localparam longint SIX_Q30 = 64'sd6 <<< 30;

    // Register reset values.
    localparam logic [PRB_W-1:0] TAIL_FRACTION_RST = 16'd6554;
    localparam logic [PRB_W-1:0] SIGMOID_SLOPE_RST = 16'd768;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERCEPT       = 3'd0,
        CFG_PERSISTENCE     = 3'd1,
        CFG_INDICATOR_GAIN  = 3'd2,
        CFG_SIZE_GAIN       = 3'd3,
        CFG_START_THRESHOLD = 3'd4,
        CFG_TAIL_FRACTION   = 3'd5,
        CFG_SIGMOID_SLOPE   = 3'd6,
        CFG_HARD_STEP       = 3'd7
    } t_cfg_idx;

    // Operand selection of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_P_SLOPE,
        MUL_IDX,
        MUL_LOSS,
        MUL_VAR,
        MUL_VZ_HI,
        MUL_VZ_LO,
        MUL_PERS,
        MUL_IND,
        MUL_SIZE
    } t_mul_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    diff;
        logic    mul_en;
        t_mul_op mul_op;
        logic    z_en;
        logic    sig_en;
        logic    acc_en;
        logic    v_en;
        logic    vzh_en;
        logic    score_en;
        logic    nf_base;
        logic    nf_ind;
        logic    nf_size;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Unsigned restoring long division, used only while building constant tables.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int b;
        q = 0;
        r = 0;
        for (b = 63; b >= 0; b--) begin
            r = (r << 1) | longint'(num[b]);
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Logistic value of the centre of cell i out of n cells over [-8, 8), Q1.16.
    function automatic logic [PROB_W-1:0] sig_cell(int i, int n);
        longint m;
        longint a;
        longint aq;
        longint t;
        longint t2;
        longint e;
        longint d;
        longint p;
        int k;
        m = 2 * longint'(i) + 1 - longint'(n);
        a = (m < 0) ? -m : m;
        aq = longint'(udiv(longint'(a) <<< 33, longint'(n)));
        t = aq >>> 8;
        t2 = (t * t) >>> 30;
        e = Q30_ONE - t + (t2 >>> 1) - (t2 * t) / SIX_Q30;
        for (k = 0; k < 8; k++) begin
            e = (e * e + (Q30_ONE >>> 1)) >>> 30;
        end
        d = Q30_ONE + e;
        p = longint'(udiv((Q30_ONE <<< 16) + (d >>> 1), d));
        if (m < 0) begin
            p = 64'sd65536 - p;
        end
        return p[PROB_W-1:0];
    endfunction

endpackage

// ----- rtl/dqtf_sample_if.sv -----
// Input channel interface: one sample beat per handshake.
interface dqtf_sample_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] sample;
    logic        first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

// ----- rtl/dqtf_result_if.sv -----
// Output channel interface: one result beat per handshake.
interface dqtf_result_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] threshold;
    logic signed [47:0] loss_sum;
    logic [31:0] sample_count;
    logic        overflow;

    modport source (output valid, output threshold, output loss_sum, output sample_count,
                    output overflow, input ready);
    modport sink   (input valid, input threshold, input loss_sum, input sample_count,
                    input overflow, output ready);
endinterface

// ----- rtl/dqtf_ctrl.sv -----
// Controller state machine that sequences one sample through the shared multiplier.
module dqtf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  dqtf_pkg::t_dp_status  i_status,
    output dqtf_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_MSLOPE,
        S_Z,
        S_MIDX,
        S_SIG,
        S_MLOSS,
        S_ACC,
        S_V,
        S_MVZH,
        S_MVZL,
        S_SCORE,
        S_NF1,
        S_NF2,
        S_NF3,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Ready only between items.
    assign o_in_ready = (r_state == S_IDLE);

    // Command decode and next state.
    always_comb begin
        o_cmd   = '0;
        o_cmd.mul_op = dqtf_pkg::MUL_P_SLOPE;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_MSLOPE;
            end
            S_MSLOPE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_P_SLOPE;
                n_state = S_Z;
            end
            S_Z: begin
                o_cmd.z_en = 1'b1;
                n_state = S_MIDX;
            end
            S_MIDX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_IDX;
                n_state = S_SIG;
            end
            S_SIG: begin
                o_cmd.sig_en = 1'b1;
                n_state = S_MLOSS;
            end
            S_MLOSS: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_LOSS;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_VAR;
                n_state = S_V;
            end
            S_V: begin
                o_cmd.v_en = 1'b1;
                n_state = S_MVZH;
            end
            S_MVZH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_VZ_HI;
                n_state = S_MVZL;
            end
            S_MVZL: begin
                o_cmd.vzh_en = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_VZ_LO;
                n_state = S_SCORE;
            end
            S_SCORE: begin
                o_cmd.score_en = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_PERS;
                n_state = S_NF1;
            end
            S_NF1: begin
                o_cmd.nf_base = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_IND;
                n_state = S_NF2;
            end
            S_NF2: begin
                o_cmd.nf_ind = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = dqtf_pkg::MUL_SIZE;
                n_state = S_NF3;
            end
            S_NF3: begin
                o_cmd.nf_size = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted beat always starts the difference step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIFF))
        else $error("accepted beat did not start processing");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded while output register busy");

    // The threshold update steps are mutually exclusive.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.nf_base, o_cmd.nf_ind, o_cmd.nf_size, o_cmd.score_en}))
        else $error("overlapping threshold update steps");

endmodule

// ----- rtl/dqtf_datapath.sv -----
// Datapath: configuration registers, shared multiplier, sigmoid table and filter state.
module dqtf_datapath #(
    parameter int SIGMOID_ENTRIES = 256,
    parameter int FRAC_BITS       = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  dqtf_pkg::t_dp_cmd     i_cmd,
    output dqtf_pkg::t_dp_status  o_status,
    input  logic signed [31:0]    i_sample,
    input  logic                  i_first,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_threshold,
    output logic signed [47:0]    o_loss_sum,
    output logic [31:0]           o_sample_count,
    output logic                  o_overflow
);

    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam int UW = FRAC_BITS + 4;
    localparam int ZW = 43;
    localparam int MW = dqtf_pkg::MUL_W;
    localparam int PW = dqtf_pkg::PROD_W;
    localparam logic signed [ZW-1:0] Z_HI = ZW'((64'sd1 <<< (FRAC_BITS + 3)) - 1);
    localparam logic signed [ZW-1:0] Z_LO = -ZW'(64'sd1 <<< (FRAC_BITS + 3));
    localparam logic signed [ZW-1:0] Z_OFS = ZW'(64'sd1 <<< (FRAC_BITS + 3));
    localparam logic signed [PW-1:0] HALF_F = PW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // Configuration registers.
    logic signed [31:0] r_intercept;
    logic signed [31:0] r_persistence;
    logic signed [31:0] r_ind_gain;
    logic signed [31:0] r_size_gain;
    logic signed [31:0] r_start;
    logic [15:0]        r_kap;
    logic [15:0]        r_slope;
    logic               r_hard;

    // Filter state and per-item working registers.
    logic signed [31:0] r_s;
    logic signed [31:0] r_f;
    logic signed [31:0] r_fn;
    logic signed [32:0] r_p;
    logic signed [ZW-1:0] r_z;
    logic [UW-1:0]      r_u;
    logic [16:0]        r_sig;
    logic signed [47:0] r_acc;
    logic [31:0]        r_cnt;
    logic               r_flag;
    logic signed [17:0] r_v;
    logic signed [63:0] r_vzh;
    logic signed [31:0] r_score;
    logic signed [63:0] r_nf;
    logic signed [PW-1:0] r_prod;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_thr;
    logic signed [47:0] r_out_loss;
    logic [31:0]        r_out_cnt;
    logic               r_out_ovf;

    // Sigmoid table built at elaboration.
    logic [16:0] w_rom [SIGMOID_ENTRIES];
    for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_rom
        assign w_rom[gi] = dqtf_pkg::sig_cell(gi, SIGMOID_ENTRIES);
    end

    // Combinational terms.
    logic signed [MW-1:0] w_a;
    logic signed [MW-1:0] w_b;
    logic signed [17:0]   w_sk;
    logic signed [PW-1:0] w_zr;
    logic signed [ZW-1:0] w_z;
    logic [UW-1:0]        w_u;
    logic [IW-1:0]        w_idx;
    logic signed [PW-1:0] w_r16;
    logic signed [49:0]   w_sum;
    logic signed [63:0]   w_vz;
    logic signed [63:0]   w_vzr;
    logic signed [63:0]   w_kt;
    logic signed [63:0]   w_score;
    logic signed [PW-1:0] w_rf;
    logic signed [63:0]   w_nfs;

    assign w_sk = $signed({1'b0, r_sig}) - $signed({2'b00, r_kap});

    // Operand selection of the shared multiplier.
    always_comb begin
        case (i_cmd.mul_op)
            dqtf_pkg::MUL_P_SLOPE: begin
                w_a = MW'(r_p);
                w_b = $signed({18'b0, r_slope});
            end
            dqtf_pkg::MUL_IDX: begin
                w_a = $signed({(MW-UW)'(0), r_u});
                w_b = MW'(SIGMOID_ENTRIES);
            end
            dqtf_pkg::MUL_LOSS: begin
                w_a = MW'(r_p);
                w_b = MW'(w_sk);
            end
            dqtf_pkg::MUL_VAR: begin
                w_a = $signed({17'b0, r_sig});
                w_b = $signed({17'b0, 17'(dqtf_pkg::PROB_ONE - r_sig)});
            end
            dqtf_pkg::MUL_VZ_HI: begin
                w_a = MW'(r_v);
                w_b = MW'($signed(r_z[ZW-1:22]));
            end
            dqtf_pkg::MUL_VZ_LO: begin
                w_a = MW'(r_v);
                w_b = $signed({12'b0, r_z[21:0]});
            end
            dqtf_pkg::MUL_PERS: begin
                w_a = MW'(r_persistence);
                w_b = MW'(r_f);
            end
            dqtf_pkg::MUL_IND: begin
                w_a = MW'(r_ind_gain);
                w_b = MW'(r_score);
            end
            dqtf_pkg::MUL_SIZE: begin
                w_a = MW'(r_size_gain);
                w_b = MW'(r_p);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Sigmoid argument, rounded, and its clamped table offset.
    assign w_zr = (r_prod + PW'(128)) >>> 8;
    assign w_z  = w_zr[ZW-1:0];
    always_comb begin
        if (w_z > Z_HI) begin
            w_u = '1;
        end else if (w_z < Z_LO) begin
            w_u = '0;
        end else begin
            w_u = UW'(w_z + Z_OFS);
        end
    end
    assign w_idx = r_prod[UW +: IW];

    // Round-half-up narrowing by 16 bits, and the saturating loss sum.
    assign w_r16 = (r_prod + PW'(32768)) >>> 16;
    assign w_sum = 50'(r_acc) + w_r16[49:0];

    // Score from the variance term and the tail probability.
    assign w_vz    = r_vzh + r_prod[63:0];
    assign w_vzr   = (w_vz + 64'sd32768) >>> 16;
    assign w_kt    = ((64'(-w_sk) <<< FRAC_BITS) + 64'sd32768) >>> 16;
    assign w_score = w_kt - w_vzr;

    // Threshold recursion terms.
    assign w_rf  = (r_prod + HALF_F) >>> FRAC_BITS;
    assign w_nfs = r_nf + w_rf[63:0];

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intercept   <= '0;
            r_persistence <= '0;
            r_ind_gain    <= '0;
            r_size_gain   <= '0;
            r_start       <= '0;
            r_kap         <= dqtf_pkg::TAIL_FRACTION_RST;
            r_slope       <= dqtf_pkg::SIGMOID_SLOPE_RST;
            r_hard        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (dqtf_pkg::t_cfg_idx'(i_cfg_idx))
                dqtf_pkg::CFG_INTERCEPT:       r_intercept   <= i_cfg_data;
                dqtf_pkg::CFG_PERSISTENCE:     r_persistence <= i_cfg_data;
                dqtf_pkg::CFG_INDICATOR_GAIN:  r_ind_gain    <= i_cfg_data;
                dqtf_pkg::CFG_SIZE_GAIN:       r_size_gain   <= i_cfg_data;
                dqtf_pkg::CFG_START_THRESHOLD: r_start       <= i_cfg_data;
                dqtf_pkg::CFG_TAIL_FRACTION:   r_kap         <= i_cfg_data[15:0];
                dqtf_pkg::CFG_SIGMOID_SLOPE:   r_slope       <= i_cfg_data[15:0];
                dqtf_pkg::CFG_HARD_STEP:       r_hard        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Filter state: threshold, loss sum, count and saturation flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f    <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_flag <= 1'b0;
        end else begin
            if (i_cmd.load && i_first) begin
                r_f    <= r_start;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_flag <= 1'b0;
            end
            if (i_cmd.acc_en) begin
                if (w_sum[49:47] != {3{w_sum[47]}}) begin
                    r_acc  <= w_sum[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                    r_flag <= 1'b1;
                end else begin
                    r_acc <= w_sum[47:0];
                end
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + 32'd1;
                end
            end
            if (i_cmd.score_en && (w_score > MAX32 || w_score < MIN32)) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.nf_size && (w_nfs > MAX32 || w_nfs < MIN32)) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_f <= r_fn;
            end
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= i_sample;
        end
        if (i_cmd.diff) begin
            r_p <= 33'(r_s) - 33'(r_f);
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.z_en) begin
            r_z <= w_z;
            r_u <= w_u;
        end
        if (i_cmd.sig_en) begin
            if (r_hard) begin
                r_sig <= (r_p > 33'sd0) ? dqtf_pkg::PROB_ONE : '0;
            end else begin
                r_sig <= w_rom[w_idx];
            end
        end
        if (i_cmd.v_en) begin
            r_v <= w_r16[17:0];
        end
        if (i_cmd.vzh_en) begin
            r_vzh <= {r_prod[41:0], 22'b0};
        end
        if (i_cmd.score_en) begin
            if (w_score > MAX32) begin
                r_score <= 32'sh7fffffff;
            end else if (w_score < MIN32) begin
                r_score <= 32'sh80000000;
            end else begin
                r_score <= w_score[31:0];
            end
        end
        if (i_cmd.nf_base) begin
            r_nf <= 64'(r_intercept) + w_rf[63:0];
        end
        if (i_cmd.nf_ind) begin
            r_nf <= r_nf - w_rf[63:0];
        end
        if (i_cmd.nf_size) begin
            if (w_nfs > MAX32) begin
                r_fn <= 32'sh7fffffff;
            end else if (w_nfs < MIN32) begin
                r_fn <= 32'sh80000000;
            end else begin
                r_fn <= w_nfs[31:0];
            end
        end
    end

    // Output register: holds a finished beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_thr  <= r_f;
            r_out_loss <= r_acc;
            r_out_cnt  <= r_cnt;
            r_out_ovf  <= r_flag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_threshold    = r_out_thr;
    assign o_loss_sum     = r_out_loss;
    assign o_sample_count = r_out_cnt;
    assign o_overflow     = r_out_ovf;

endmodule

// ----- rtl/dynamic_quantile_threshold_filter.sv -----
// Top level of the dynamic quantile threshold filter.
//
// One sample beat enters on i_in; each produces exactly one result beat on o_out carrying
// the threshold in force for that sample, the running tick-loss sum and sample count of
// the series, and the saturation flag. A beat with first set reloads the start threshold
// and clears the sum, the count and the flag before the sample is used.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while no
// sample is in flight; an index has no effect outside the register list.
// From acceptance to a valid result, the threshold recursion runs as a chain of nine
// dependent products on one shared 34x34 multiplier, plus the table lookup, rounding and
// saturation steps. The next sample is accepted in the cycle after the result is loaded
// into the output register; no new sample is taken while one is still in flight.
// The output register holds its beat while the receiver stalls; the block then accepts
// and computes the next sample and waits only to load its result.
// Reset (synchronous, active low) sets the registers to their defaults, the threshold,
// sum, count and flag to zero, and empties the output register.
module dynamic_quantile_threshold_filter #(
    parameter int SIGMOID_ENTRIES = 256,
    parameter int FRAC_BITS       = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    dqtf_sample_if.sink    i_in,
    dqtf_result_if.source  o_out
);

    dqtf_pkg::t_dp_cmd    w_cmd;
    dqtf_pkg::t_dp_status w_status;
    logic                 w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer.
    dqtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state.
    dqtf_datapath #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES),
        .FRAC_BITS       (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample       (i_in.sample),
        .i_first        (i_in.first),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_threshold    (o_out.threshold),
        .o_loss_sum     (o_out.loss_sum),
        .o_sample_count (o_out.sample_count),
        .o_overflow     (o_out.overflow)
    );

endmodule

// ----- dv/dynamic_quantile_threshold_filter_test.sv -----
// Self-checking testbench of the dynamic quantile threshold filter with its own predictor.
`timescale 1ns / 100ps

module dynamic_quantile_threshold_filter_test;

    localparam int N_CELLS = 256;
    localparam int FRAC    = 16;
    localparam longint ONE = 64'sd1 <<< FRAC;
    localparam longint Q30 = 64'sd1 <<< 30;
    localparam longint LOSS_HI = (64'sd1 <<< 47) - 1;
    localparam longint LOSS_LO = -(64'sd1 <<< 47);

    typedef struct {
        logic signed [31:0] sample;
        logic               first;
    } t_sample_beat;

    typedef struct {
        logic signed [31:0] threshold;
        logic signed [47:0] loss_sum;
        logic [31:0]        sample_count;
        logic               overflow;
    } t_result_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    dqtf_sample_if sample_ch ();
    dqtf_result_if result_ch ();

    dynamic_quantile_threshold_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch.sink),
        .o_out      (result_ch.source)
    );

    // Predictor state: registers, threshold recursion state and the logistic table.
    logic signed [31:0] cfg_intercept, cfg_persistence, cfg_ind_gain, cfg_size_gain;
    logic signed [31:0] cfg_start;
    logic [15:0]        cfg_tail, cfg_slope;
    logic               cfg_step;
    longint             thr_now, loss_now;
    logic [31:0]        count_now;
    logic               sat_now;
    longint             logistic_cell [N_CELLS];

    t_sample_beat pending_samples [$];
    t_result_beat expected_results [$];
    t_sample_beat drive_beat;
    int           fail_count;
    int           burst_left, gap_left;
    int           stall_left, run_left, results_seen;
    logic         long_hold_done;

    // Round half up at k fractional bits.
    function automatic longint round_shift(longint x, int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint sat32(longint x, ref logic flag);
        if (x > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Logistic of each cell centre, Q30 series followed by eight squarings.
    task automatic build_logistic_cells();
        longint m, a, aq, t, t2, e, d, p;
        for (int i = 0; i < N_CELLS; i++) begin
            m = 2 * i + 1 - N_CELLS;
            a = (m < 0) ? -m : m;
            aq = (a <<< 33) / N_CELLS;
            t = aq >>> 8;
            t2 = (t * t) >>> 30;
            e = Q30 - t + (t2 >>> 1) - (t2 * t) / (6 * Q30);
            for (int k = 0; k < 8; k++) begin
                e = (e * e + (Q30 >>> 1)) >>> 30;
            end
            d = Q30 + e;
            p = ((Q30 <<< 16) + (d >>> 1)) / d;
            logistic_cell[i] = (m < 0) ? 65536 - p : p;
        end
    endtask

    // One accepted sample: update the threshold recursion and queue its result.
    task automatic advance_threshold(t_sample_beat b);
        longint f, p, kap, z, zc, idx, sig, inc, v, score, nf;
        t_result_beat r;
        if (b.first) begin
            thr_now = cfg_start;
            loss_now = 0;
            count_now = 0;
            sat_now = 1'b0;
        end
        f = thr_now;
        p = longint'(b.sample) - f;
        kap = cfg_tail;
        z = round_shift(p * longint'(cfg_slope), 8);
        if (cfg_step) begin
            sig = (p > 0) ? 65536 : 0;
        end else begin
            zc = z;
            if (zc > 8 * ONE - 1) zc = 8 * ONE - 1;
            if (zc < -8 * ONE) zc = -8 * ONE;
            idx = ((zc + 8 * ONE) * N_CELLS) >>> (FRAC + 4);
            if (idx < 0) idx = 0;
            if (idx > N_CELLS - 1) idx = N_CELLS - 1;
            sig = logistic_cell[idx];
        end
        inc = round_shift(p * (sig - kap), 16);
        loss_now = loss_now + inc;
        if (loss_now > LOSS_HI) begin
            loss_now = LOSS_HI;
            sat_now = 1'b1;
        end
        if (loss_now < LOSS_LO) begin
            loss_now = LOSS_LO;
            sat_now = 1'b1;
        end
        if (count_now != 32'hFFFF_FFFF) count_now++;
        v = round_shift(sig * (65536 - sig), 16);
        score = round_shift((kap - sig) * ONE, 16) - round_shift(v * z, 16);
        score = sat32(score, sat_now);
        nf = longint'(cfg_intercept)
           + round_shift(longint'(cfg_persistence) * f, FRAC)
           - round_shift(longint'(cfg_ind_gain) * score, FRAC)
           + round_shift(longint'(cfg_size_gain) * p, FRAC);
        thr_now = sat32(nf, sat_now);
        r.threshold = f[31:0];
        r.loss_sum = loss_now[47:0];
        r.sample_count = count_now;
        r.overflow = sat_now;
        expected_results.push_back(r);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of beats from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            sample_ch.sample <= '0;
            sample_ch.first <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (sample_ch.valid && !sample_ch.ready) begin
            // Hold the offered beat.
        end else begin
            if (sample_ch.valid) advance_threshold(drive_beat);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                sample_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                drive_beat = pending_samples.pop_front();
                sample_ch.sample <= drive_beat.sample;
                sample_ch.first <= drive_beat.first;
                sample_ch.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall pattern, one long hold-off, and the result check.
    always @(posedge i_clk) begin
        t_result_beat exp_r;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left <= 0;
            run_left <= 0;
            results_seen <= 0;
            long_hold_done <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation pending");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (result_ch.threshold !== exp_r.threshold) begin
                        $error("threshold: expected %0d actual %0d",
                               exp_r.threshold, result_ch.threshold);
                        fail_count++;
                    end
                    if (result_ch.loss_sum !== exp_r.loss_sum) begin
                        $error("loss_sum: expected %0d actual %0d",
                               exp_r.loss_sum, result_ch.loss_sum);
                        fail_count++;
                    end
                    if (result_ch.sample_count !== exp_r.sample_count) begin
                        $error("sample_count: expected %0d actual %0d",
                               exp_r.sample_count, result_ch.sample_count);
                        fail_count++;
                    end
                    if (result_ch.overflow !== exp_r.overflow) begin
                        $error("overflow: expected %0d actual %0d",
                               exp_r.overflow, result_ch.overflow);
                        fail_count++;
                    end
                end
            end
            if (!long_hold_done && results_seen == 300) begin
                // Long hold-off so the output register fills and input backs up.
                long_hold_done <= 1'b1;
                stall_left <= 600;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left <= run_left - 1;
                result_ch.ready <= 1'b1;
            end else begin
                run_left <= $urandom_range(0, 60);
                stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Register write at the clock edge, mirrored into the predictor.
    task automatic write_reg(dqtf_pkg::t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            dqtf_pkg::CFG_INTERCEPT:       cfg_intercept = data;
            dqtf_pkg::CFG_PERSISTENCE:     cfg_persistence = data;
            dqtf_pkg::CFG_INDICATOR_GAIN:  cfg_ind_gain = data;
            dqtf_pkg::CFG_SIZE_GAIN:       cfg_size_gain = data;
            dqtf_pkg::CFG_START_THRESHOLD: cfg_start = data;
            dqtf_pkg::CFG_TAIL_FRACTION:   cfg_tail = data[15:0];
            dqtf_pkg::CFG_SIGMOID_SLOPE:   cfg_slope = data[15:0];
            dqtf_pkg::CFG_HARD_STEP:       cfg_step = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(logic [31:0] s, logic first);
        t_sample_beat b;
        b.sample = s;
        b.first = first;
        pending_samples.push_back(b);
    endtask

    // Stimulus waits until every expected result has arrived and the block is quiet.
    task automatic wait_drained();
        while (pending_samples.size() > 0 || sample_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random beats: mostly samples near the start threshold, with new series now and then.
    task automatic random_series(int n, int span);
        logic [31:0] s;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1: s = $urandom;
                2: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: s = cfg_start + $signed($urandom_range(0, 2 * span) - span);
            endcase
            push_sample(s, (i == 0) || ($urandom_range(0, 40) == 0));
        end
    endtask

    task automatic set_gains(logic [31:0] c, logic [31:0] pe, logic [31:0] ig,
                             logic [31:0] sg, logic [31:0] st);
        write_reg(dqtf_pkg::CFG_INTERCEPT, c);
        write_reg(dqtf_pkg::CFG_PERSISTENCE, pe);
        write_reg(dqtf_pkg::CFG_INDICATOR_GAIN, ig);
        write_reg(dqtf_pkg::CFG_SIZE_GAIN, sg);
        write_reg(dqtf_pkg::CFG_START_THRESHOLD, st);
    endtask

    // Stimulus and end of run.
    initial begin
        fail_count = 0;
        cfg_intercept = 0; cfg_persistence = 0; cfg_ind_gain = 0; cfg_size_gain = 0;
        cfg_start = 0; cfg_tail = 16'd6554; cfg_slope = 16'd768; cfg_step = 1'b0;
        thr_now = 0; loss_now = 0; count_now = 0; sat_now = 1'b0;
        build_logistic_cells();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        sample_ch.first = 1'b0;
        result_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no series start after reset, field extremes, then a new series.
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        wait_drained();

        // Typical score-driven setting, sigmoid mode.
        set_gains(32'sd3277, 32'sd58982, 32'sd32768, 32'sd6554, 32'sd65536);
        write_reg(dqtf_pkg::CFG_TAIL_FRACTION, 32'd6554);
        write_reg(dqtf_pkg::CFG_SIGMOID_SLOPE, 32'd768);
        write_reg(dqtf_pkg::CFG_HARD_STEP, 32'd0);
        random_series(180, 200000);
        wait_drained();

        // Step indicator; the step sits exactly at a zero exceedance.
        write_reg(dqtf_pkg::CFG_HARD_STEP, 32'd1);
        push_sample(32'sd65536, 1'b1);
        push_sample(32'sd65536, 1'b1);
        push_sample(32'sd65537, 1'b1);
        random_series(130, 300000);
        wait_drained();

        // Zero slope, extreme tail fractions.
        write_reg(dqtf_pkg::CFG_HARD_STEP, 32'd0);
        write_reg(dqtf_pkg::CFG_SIGMOID_SLOPE, 32'd0);
        write_reg(dqtf_pkg::CFG_TAIL_FRACTION, 32'd65535);
        random_series(90, 200000);
        wait_drained();
        write_reg(dqtf_pkg::CFG_SIGMOID_SLOPE, 32'd65535);
        write_reg(dqtf_pkg::CFG_TAIL_FRACTION, 32'd0);
        random_series(90, 4000);
        wait_drained();

        // Extreme gains drive the score, threshold and loss into saturation.
        set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        write_reg(dqtf_pkg::CFG_TAIL_FRACTION, 32'd65535);
        write_reg(dqtf_pkg::CFG_SIGMOID_SLOPE, 32'd768);
        random_series(90, 200000);
        wait_drained();
        set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_reg(dqtf_pkg::CFG_HARD_STEP, 32'd1);
        random_series(90, 200000);
        wait_drained();

        // Fully random registers.
        set_gains($urandom, $urandom, $urandom, $urandom, $urandom);
        write_reg(dqtf_pkg::CFG_TAIL_FRACTION, $urandom);
        write_reg(dqtf_pkg::CFG_SIGMOID_SLOPE, $urandom);
        write_reg(dqtf_pkg::CFG_HARD_STEP, $urandom);
        random_series(90, 200000);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (expected_results.size() > 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dqtf_pkg.sv
rtl/dqtf_sample_if.sv
rtl/dqtf_result_if.sv
rtl/dqtf_ctrl.sv
rtl/dqtf_datapath.sv
rtl/dynamic_quantile_threshold_filter.sv
dv/dynamic_quantile_threshold_filter_test.sv
